// ----- hdl/tlx_pkg.sv -----
package tlx_pkg;

    // longest lexeme kept, longer ones are cut and flagged
    localparam int MAX_LEN = 32;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // character ring holds the pending token plus finished tokens not yet drained
    localparam int CB_AW = $clog2(2 * MAX_LEN);
    localparam int CB_DEPTH = 2 ** CB_AW;
    localparam int PTR_W = CB_AW + 1;

    // token descriptor queue
    localparam int DQ_DEPTH = 4;
    localparam int DQ_AW = $clog2(DQ_DEPTH);
    localparam int DQ_CW = DQ_AW + 1;

    localparam int KW_NUM = 6;

    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [PTR_W-1:0] CB_FULL_OCC = PTR_W'(CB_DEPTH);
    localparam logic [DQ_CW-1:0] DQ_FULL_CNT = DQ_CW'(DQ_DEPTH);
    localparam logic [DQ_CW-1:0] DQ_CNT_ONE = DQ_CW'(1);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END = 1'b1;

    localparam logic [4:0] KIND_IDENT = 5'd0;
    localparam logic [4:0] KIND_NUMBER = 5'd1;
    localparam logic [4:0] KIND_KW_BASE = 5'd2;
    localparam logic [4:0] KIND_PUNCT_BASE = 5'd8;
    localparam logic [4:0] KIND_ASSIGN = 5'd18;
    localparam logic [4:0] KIND_EQ = 5'd19;
    localparam logic [4:0] KIND_ERROR = 5'd20;

    localparam logic [3:0] PUNCT_NONE = 4'hf;

    typedef enum logic [2:0] {
        CL_ALPHA = 3'd0,
        CL_DIGIT = 3'd1,
        CL_PUNCT = 3'd2,
        CL_EQ    = 3'd3,
        CL_SPACE = 3'd4,
        CL_OTHER = 3'd5
    } t_cls;

    typedef enum logic [5:0] {
        S_START = 6'b000001,
        S_IDENT = 6'b000010,
        S_NUM   = 6'b000100,
        S_EQ1   = 6'b001000,
        S_EQ2   = 6'b010000,
        S_PUNCT = 6'b100000
    } t_dfa;

    typedef struct packed {
        logic [4:0]       kind;
        logic [LEN_W-1:0] len;
        logic             trunc;
        logic             err;
    } t_desc;

    typedef struct packed {
        logic  en;
        t_desc desc;
    } t_dpush;

    typedef struct packed {
        logic             en;
        logic [CB_AW-1:0] addr;
        logic [7:0]       data;
    } t_cwr;

    typedef struct packed {
        logic             en;
        logic [CB_AW-1:0] addr;
    } t_crd;

    function automatic logic [3:0] punct_idx(input logic [7:0] b);
        logic [3:0] idx;
        case (b)
            8'h3b:   idx = 4'd0;
            8'h28:   idx = 4'd1;
            8'h29:   idx = 4'd2;
            8'h7b:   idx = 4'd3;
            8'h7d:   idx = 4'd4;
            8'h2b:   idx = 4'd5;
            8'h2a:   idx = 4'd6;
            8'h2f:   idx = 4'd7;
            8'h3c:   idx = 4'd8;
            8'h3e:   idx = 4'd9;
            default: idx = PUNCT_NONE;
        endcase
        return idx;
    endfunction

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        priority if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f) begin
            c = CL_ALPHA;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CL_DIGIT;
        end else if (b == 8'h3d) begin
            c = CL_EQ;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0a) begin
            c = CL_SPACE;
        end else if (punct_idx(b) != PUNCT_NONE) begin
            c = CL_PUNCT;
        end else begin
            c = CL_OTHER;
        end
        return c;
    endfunction

    // keyword lengths: if else while break continue return
    function automatic logic [LEN_W-1:0] kw_len(input logic [2:0] k);
        logic [LEN_W-1:0] n;
        case (k)
            3'd0:    n = LEN_W'(2);
            3'd1:    n = LEN_W'(4);
            3'd2:    n = LEN_W'(5);
            3'd3:    n = LEN_W'(5);
            3'd4:    n = LEN_W'(8);
            3'd5:    n = LEN_W'(6);
            default: n = '0;
        endcase
        return n;
    endfunction

    // keyword text, first character in the low byte
    function automatic logic kw_hit(input logic [2:0] k, input logic [2:0] pos,
                                    input logic [7:0] b);
        logic [63:0] w;
        case (k)
            3'd0:    w = 64'h0000_0000_0000_6669;
            3'd1:    w = 64'h0000_0000_6573_6c65;
            3'd2:    w = 64'h0000_0065_6c69_6877;
            3'd3:    w = 64'h0000_006b_6165_7262;
            3'd4:    w = 64'h6575_6e69_746e_6f63;
            3'd5:    w = 64'h0000_6e72_7574_6572;
            default: w = '0;
        endcase
        return w[{pos, 3'b000} +: 8] == b;
    endfunction

endpackage

// ----- hdl/tlx_front.sv -----
module tlx_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_command,
    input  logic [7:0]                i_byte_in,
    input  logic                      i_dq_full,
    input  logic [tlx_pkg::PTR_W-1:0] i_rd_ptr,
    output tlx_pkg::t_cwr             o_cw,
    output tlx_pkg::t_dpush           o_dpush
);

    tlx_pkg::t_dfa r_state, n_state;
    logic [tlx_pkg::LEN_W-1:0] r_len, n_len;
    logic r_ovf, n_ovf;
    logic r_halt, n_halt;
    logic [tlx_pkg::KW_NUM-1:0] r_match, n_match;
    logic [4:0] r_punct_kind, n_punct_kind;
    logic [tlx_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [tlx_pkg::PTR_W-1:0] r_tok_start, n_tok_start;

    tlx_pkg::t_cls cls;
    tlx_pkg::t_dfa cont_state;
    logic cont;
    logic go_err;
    logic acc;
    logic [tlx_pkg::PTR_W-1:0] occ;
    logic [4:0] tok_kind;
    logic [tlx_pkg::LEN_W-1:0] base_len;
    logic [tlx_pkg::KW_NUM-1:0] base_match;

    function automatic tlx_pkg::t_dfa start_next(input tlx_pkg::t_cls c);
        tlx_pkg::t_dfa s;
        case (c)
            tlx_pkg::CL_ALPHA: s = tlx_pkg::S_IDENT;
            tlx_pkg::CL_DIGIT: s = tlx_pkg::S_NUM;
            tlx_pkg::CL_PUNCT: s = tlx_pkg::S_PUNCT;
            tlx_pkg::CL_EQ:    s = tlx_pkg::S_EQ1;
            default:           s = tlx_pkg::S_START;
        endcase
        return s;
    endfunction

    // kind of the pending token
    always_comb begin
        tok_kind = tlx_pkg::KIND_IDENT;
        unique case (r_state)
            tlx_pkg::S_IDENT: begin
                for (int k = tlx_pkg::KW_NUM - 1; k >= 0; k--) begin
                    if (r_match[k] && !r_ovf && r_len == tlx_pkg::kw_len(3'(k))) begin
                        tok_kind = tlx_pkg::KIND_KW_BASE + 5'(k);
                    end
                end
            end
            tlx_pkg::S_NUM:   tok_kind = tlx_pkg::KIND_NUMBER;
            tlx_pkg::S_EQ1:   tok_kind = tlx_pkg::KIND_ASSIGN;
            tlx_pkg::S_EQ2:   tok_kind = tlx_pkg::KIND_EQ;
            tlx_pkg::S_PUNCT: tok_kind = r_punct_kind;
            default:          tok_kind = tlx_pkg::KIND_IDENT;
        endcase
    end

    // whether the byte extends the pending token
    always_comb begin
        cls = tlx_pkg::classify(i_byte_in);
        go_err = (cls == tlx_pkg::CL_OTHER);
        cont = 1'b0;
        cont_state = r_state;
        unique case (r_state)
            tlx_pkg::S_IDENT: begin
                cont = (cls == tlx_pkg::CL_ALPHA) || (cls == tlx_pkg::CL_DIGIT);
            end
            tlx_pkg::S_NUM: begin
                cont = (cls == tlx_pkg::CL_DIGIT);
            end
            tlx_pkg::S_EQ1: begin
                cont = (cls == tlx_pkg::CL_EQ);
                cont_state = tlx_pkg::S_EQ2;
            end
            tlx_pkg::S_EQ2, tlx_pkg::S_PUNCT: begin
                cont = 1'b0;
            end
            default: begin
                cont = (cls != tlx_pkg::CL_SPACE);
                cont_state = start_next(cls);
            end
        endcase
    end

    assign occ = r_wr_ptr - i_rd_ptr;
    assign full = (occ == tlx_pkg::CB_FULL_OCC) || i_dq_full;
    assign acc = push && !full;

    always_comb begin
        n_state = r_state;
        n_len = r_len;
        n_ovf = r_ovf;
        n_halt = r_halt;
        n_match = r_match;
        n_punct_kind = r_punct_kind;
        n_wr_ptr = r_wr_ptr;
        n_tok_start = r_tok_start;
        base_len = r_len;
        base_match = r_match;
        o_cw.en = 1'b0;
        o_cw.addr = r_wr_ptr[tlx_pkg::CB_AW-1:0];
        o_cw.data = i_byte_in;
        o_dpush.en = 1'b0;
        o_dpush.desc.kind = tok_kind;
        o_dpush.desc.len = r_len;
        o_dpush.desc.trunc = r_ovf;
        o_dpush.desc.err = 1'b0;

        if (acc) begin
            if (i_command == tlx_pkg::CMD_END) begin
                // flush the pending word, then back to reset state
                o_dpush.en = !r_halt && (r_len != '0);
                n_state = tlx_pkg::S_START;
                n_len = '0;
                n_ovf = 1'b0;
                n_halt = 1'b0;
                n_tok_start = r_wr_ptr;
            end else if (!r_halt) begin
                if (go_err) begin
                    // drop pending chars, report one error word
                    o_dpush.en = 1'b1;
                    o_dpush.desc.kind = tlx_pkg::KIND_ERROR;
                    o_dpush.desc.len = tlx_pkg::LEN_ONE;
                    o_dpush.desc.trunc = 1'b0;
                    o_dpush.desc.err = 1'b1;
                    n_wr_ptr = r_tok_start;
                    n_state = tlx_pkg::S_START;
                    n_len = '0;
                    n_ovf = 1'b0;
                    n_halt = 1'b1;
                end else begin
                    if (!cont) begin
                        o_dpush.en = (r_len != '0);
                        n_state = start_next(cls);
                        n_len = '0;
                        n_ovf = 1'b0;
                        n_tok_start = r_wr_ptr;
                        base_len = '0;
                    end else begin
                        n_state = cont_state;
                    end
                    if (base_len == '0) begin
                        base_match = '1;
                    end
                    if (cls != tlx_pkg::CL_SPACE) begin
                        if (base_len < tlx_pkg::LEN_MAX) begin
                            o_cw.en = 1'b1;
                            n_wr_ptr = r_wr_ptr + tlx_pkg::PTR_ONE;
                            n_len = base_len + tlx_pkg::LEN_ONE;
                            for (int k = 0; k < tlx_pkg::KW_NUM; k++) begin
                                n_match[k] = base_match[k]
                                    && (base_len < tlx_pkg::kw_len(3'(k)))
                                    && tlx_pkg::kw_hit(3'(k), base_len[2:0], i_byte_in);
                            end
                            if (base_len == '0) begin
                                n_punct_kind = tlx_pkg::KIND_PUNCT_BASE
                                    + {1'b0, tlx_pkg::punct_idx(i_byte_in)};
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlx_pkg::S_START;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_halt <= 1'b0;
            r_wr_ptr <= '0;
            r_tok_start <= '0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_halt <= n_halt;
            r_wr_ptr <= n_wr_ptr;
            r_tok_start <= n_tok_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        r_punct_kind <= n_punct_kind;
    end

endmodule

// ----- hdl/tlx_queue.sv -----
module tlx_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlx_pkg::t_cwr             i_cw,
    input  tlx_pkg::t_crd             i_rd,
    output logic [7:0]                o_rd_data,
    input  tlx_pkg::t_dpush           i_dpush,
    input  logic                      i_dpop,
    output tlx_pkg::t_desc            o_dhead,
    output logic                      o_dq_avail,
    output logic                      o_dq_full
);

    logic [7:0] r_cbuf [tlx_pkg::CB_DEPTH];
    logic [7:0] r_rd_data;

    tlx_pkg::t_desc r_dq [tlx_pkg::DQ_DEPTH];
    logic [tlx_pkg::DQ_AW-1:0] r_dq_wp, n_dq_wp;
    logic [tlx_pkg::DQ_AW-1:0] r_dq_rp, n_dq_rp;
    logic [tlx_pkg::DQ_CW-1:0] r_dq_cnt, n_dq_cnt;

    // character ring, registered read
    always_ff @(posedge i_clk) begin
        if (i_cw.en) begin
            r_cbuf[i_cw.addr] <= i_cw.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_cbuf[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

    always_comb begin
        n_dq_wp = r_dq_wp;
        n_dq_rp = r_dq_rp;
        n_dq_cnt = r_dq_cnt;
        if (i_dpush.en) begin
            n_dq_wp = r_dq_wp + 1'b1;
            n_dq_cnt = n_dq_cnt + tlx_pkg::DQ_CNT_ONE;
        end
        if (i_dpop) begin
            n_dq_rp = r_dq_rp + 1'b1;
            n_dq_cnt = n_dq_cnt - tlx_pkg::DQ_CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq_wp <= '0;
            r_dq_rp <= '0;
            r_dq_cnt <= '0;
        end else begin
            r_dq_wp <= n_dq_wp;
            r_dq_rp <= n_dq_rp;
            r_dq_cnt <= n_dq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dpush.en) begin
            r_dq[r_dq_wp] <= i_dpush.desc;
        end
    end

    assign o_dhead = r_dq[r_dq_rp];
    assign o_dq_avail = (r_dq_cnt != '0);
    assign o_dq_full = (r_dq_cnt == tlx_pkg::DQ_FULL_CNT);

endmodule

// ----- hdl/tlx_back.sv -----
module tlx_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlx_pkg::t_desc            i_dhead,
    input  logic                      i_dq_avail,
    output logic                      o_dpop,
    output tlx_pkg::t_crd             o_rd,
    input  logic [7:0]                i_rd_data,
    output logic [tlx_pkg::PTR_W-1:0] o_rd_ptr,
    output logic                      empty,
    input  logic                      pop,
    output logic [4:0]                o_token_kind,
    output logic [7:0]                o_lexeme_char,
    output logic                      o_last,
    output logic                      o_truncated
);

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_result;

    // token being drained
    logic r_busy, n_busy;
    logic [tlx_pkg::LEN_W-1:0] r_rem, n_rem;
    logic [4:0] r_kind, n_kind;
    logic r_trunc, n_trunc;
    logic r_err, n_err;
    logic [tlx_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;

    // word whose char read is in flight
    logic r_inf;
    logic [4:0] r_inf_kind;
    logic r_inf_last;
    logic r_inf_trunc;
    logic r_inf_err;

    // two-entry output queue
    t_result r_oq [2];
    logic r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt, n_oq_cnt;

    logic do_pop;
    logic issue;
    logic is_last;
    logic room;
    logic [2:0] occ;
    t_result res;

    assign do_pop = pop && (r_oq_cnt != 2'd0);
    assign occ = {1'b0, r_oq_cnt} + {2'b00, r_inf} - {2'b00, do_pop};
    assign room = (occ < 3'd2);
    assign issue = r_busy && room;
    assign is_last = (r_rem == tlx_pkg::LEN_ONE);
    assign o_dpop = !r_busy && i_dq_avail;

    assign o_rd.en = issue && !r_err;
    assign o_rd.addr = r_rd_ptr[tlx_pkg::CB_AW-1:0];
    assign o_rd_ptr = r_rd_ptr;

    always_comb begin
        n_busy = r_busy;
        n_rem = r_rem;
        n_kind = r_kind;
        n_trunc = r_trunc;
        n_err = r_err;
        n_rd_ptr = r_rd_ptr;
        if (issue) begin
            n_rem = r_rem - tlx_pkg::LEN_ONE;
            if (is_last) begin
                n_busy = 1'b0;
            end
            if (!r_err) begin
                n_rd_ptr = r_rd_ptr + tlx_pkg::PTR_ONE;
            end
        end
        if (o_dpop) begin
            n_busy = 1'b1;
            n_rem = i_dhead.len;
            n_kind = i_dhead.kind;
            n_trunc = i_dhead.trunc;
            n_err = i_dhead.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem <= '0;
            r_rd_ptr <= '0;
            r_inf <= 1'b0;
            r_oq_wp <= 1'b0;
            r_oq_rp <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_rem <= n_rem;
            r_rd_ptr <= n_rd_ptr;
            r_inf <= issue;
            r_oq_wp <= r_oq_wp ^ r_inf;
            r_oq_rp <= r_oq_rp ^ do_pop;
            r_oq_cnt <= n_oq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_trunc <= n_trunc;
        r_err <= n_err;
        if (issue) begin
            r_inf_kind <= r_kind;
            r_inf_last <= is_last;
            r_inf_trunc <= r_trunc;
            r_inf_err <= r_err;
        end
        if (r_inf) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    // error word carries a zero char
    always_comb begin
        res.kind = r_inf_kind;
        res.ch = r_inf_err ? 8'h00 : i_rd_data;
        res.last = r_inf_last;
        res.trunc = r_inf_trunc;
    end

    assign n_oq_cnt = r_oq_cnt + {1'b0, r_inf} - {1'b0, do_pop};

    assign empty = (r_oq_cnt == 2'd0);
    assign o_token_kind = r_oq[r_oq_rp].kind;
    assign o_lexeme_char = r_oq[r_oq_rp].ch;
    assign o_last = r_oq[r_oq_rp].last;
    assign o_truncated = r_oq[r_oq_rp].trunc;

endmodule

// ----- hdl/token_lexer_dfa.sv -----
// path: the byte that ends a token pushes its descriptor; the back end loads it, reads the ring, fills the output queue
// throughput: one byte per cycle while the char ring and token queue have room
// drain: one char word per cycle while the output is popped, with a descriptor load between tokens
// reset: synchronous, active low; clears pointers, counts and dfa state, no clearing pass
module token_lexer_dfa (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_command,
    input  logic [7:0] i_byte_in,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] o_token_kind,
    output logic [7:0] o_lexeme_char,
    output logic       o_last,
    output logic       o_truncated
);

    // front to queue: char writes and finished-token descriptors
    tlx_pkg::t_cwr   cw;
    tlx_pkg::t_dpush dpush;

    // queue to back: head descriptor and char ring read port
    tlx_pkg::t_desc  dhead;
    tlx_pkg::t_crd   crd;
    logic [7:0]      rd_data;
    logic            dq_avail;
    logic            dq_full;
    logic            dpop;

    // back to front: committed read pointer frees ring slots
    logic [tlx_pkg::PTR_W-1:0] rd_ptr;

    // front: classifies each byte, runs the dfa, keeps the pending lexeme in the
    // ring and tracks keyword prefixes so the kind is known when the token ends
    tlx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_command (i_command),
        .i_byte_in (i_byte_in),
        .i_dq_full (dq_full),
        .i_rd_ptr  (rd_ptr),
        .o_cw      (cw),
        .o_dpush   (dpush)
    );

    // decoupling storage: char ring memory plus a short token descriptor fifo
    tlx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cw       (cw),
        .i_rd       (crd),
        .o_rd_data  (rd_data),
        .i_dpush    (dpush),
        .i_dpop     (dpop),
        .o_dhead    (dhead),
        .o_dq_avail (dq_avail),
        .o_dq_full  (dq_full)
    );

    // back: walks each descriptor, reads its chars and fills the output queue
    tlx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dhead       (dhead),
        .i_dq_avail    (dq_avail),
        .o_dpop        (dpop),
        .o_rd          (crd),
        .i_rd_data     (rd_data),
        .o_rd_ptr      (rd_ptr),
        .empty         (empty),
        .pop           (pop),
        .o_token_kind  (o_token_kind),
        .o_lexeme_char (o_lexeme_char),
        .o_last        (o_last),
        .o_truncated   (o_truncated)
    );

`ifndef ASSERT_OFF
    // a descriptor is never pushed into a full token queue
    a_dq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dpush.en |-> !dq_full)
        else $error("token queue overflow");

    // the error word is a single last word with a zero char
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == tlx_pkg::KIND_ERROR)
            |-> (o_last && o_lexeme_char == 8'h00 && !o_truncated))
        else $error("malformed error word");

    // output kinds stay within the defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_token_kind <= tlx_pkg::KIND_ERROR))
        else $error("token kind out of range");

    // nothing waits on the output right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");
`endif

endmodule

// ----- bench/token_lexer_dfa_tb.sv -----
module token_lexer_dfa_tb;
    import tlx_pkg::*;

    // run shape
    localparam int LIMIT_TIME    = 2_000_000;  // watchdog, far above the slowest legal run
    localparam int RANDOM_WORDS  = 225;        // random words that the lexer acts on
    localparam int HOLD_AFTER    = 40;         // input words accepted before the long pop hold
    localparam int HOLD_CYCLES   = 400;        // long enough to fill the char ring and token queue
    localparam int DRAIN_LIMIT   = 20_000;     // cycles allowed for the last char words to drain
    localparam int SETTLE_CYCLES = 30;         // quiet time at the end to catch stray char words

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_TRICKLE
    } t_rx_mode;

    // one char word as the block hands it out
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_char_word;

    // one source word: a byte or the end-of-input marker
    typedef struct {
        logic       cmd;
        logic [7:0] ch;
    } t_src_word;

    // lexer shadow plus the queue of char words it has promised
    class lexer_scoreboard;
        t_dfa       dfa;
        logic [7:0] lex_text[MAX_LEN];
        int         lex_len;
        bit         cut;
        bit         halted;
        t_char_word chars_due[$];
        int         n_in, n_out, n_tokens, n_keywords, n_cut, n_errors, n_fail;

        function new();
            clear_token();
            halted = 1'b0;
            n_in = 0;
            n_out = 0;
            n_tokens = 0;
            n_keywords = 0;
            n_cut = 0;
            n_errors = 0;
            n_fail = 0;
        endfunction

        static function t_cls char_class(logic [7:0] c);
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CL_ALPHA;
            if (c >= "0" && c <= "9") return CL_DIGIT;
            if (c == "=") return CL_EQ;
            if (c == " " || c == 8'h09 || c == 8'h0a) return CL_SPACE;
            if (symbol_slot(c) >= 0) return CL_PUNCT;
            return CL_OTHER;
        endfunction

        static function int symbol_slot(logic [7:0] c);
            string marks;
            marks = ";(){}+*/<>";
            for (int i = 0; i < marks.len(); i++) begin
                if (c == marks[i]) return i;
            end
            return -1;
        endfunction

        function int pending();
            return chars_due.size();
        endfunction

        function void clear_token();
            lex_len = 0;
            cut = 1'b0;
            dfa = S_START;
        endfunction

        function void due(logic [4:0] kind, logic [7:0] ch, logic last, logic trunc);
            t_char_word w;
            w.kind = kind;
            w.ch = ch;
            w.last = last;
            w.trunc = trunc;
            chars_due.insert(chars_due.size(), w);
        endfunction

        // state a token takes on when this class opens it
        function t_dfa open_state(t_cls cls);
            case (cls)
                CL_ALPHA: return S_IDENT;
                CL_DIGIT: return S_NUM;
                CL_PUNCT: return S_PUNCT;
                CL_EQ:    return S_EQ1;
                default:  return S_START;
            endcase
        endfunction

        // does this class grow the pending token rather than close it
        function bit grows(t_cls cls);
            case (dfa)
                S_START: return 1'b1;
                S_IDENT: return cls == CL_ALPHA || cls == CL_DIGIT;
                S_NUM:   return cls == CL_DIGIT;
                S_EQ1:   return cls == CL_EQ;
                default: return 1'b0;
            endcase
        endfunction

        // keyword match, exact length and text only
        function logic [4:0] ident_kind();
            string words[KW_NUM];
            bit    same;
            words = '{"if", "else", "while", "break", "continue", "return"};
            for (int k = 0; k < KW_NUM; k++) begin
                if (words[k].len() == lex_len) begin
                    same = 1'b1;
                    for (int j = 0; j < lex_len; j++) begin
                        if (lex_text[j] != words[k][j]) same = 1'b0;
                    end
                    if (same) return KIND_KW_BASE + 5'(k);
                end
            end
            return KIND_IDENT;
        endfunction

        // queue one char word per stored character of the pending token
        function void emit_pending();
            logic [4:0] k;
            if (lex_len == 0) return;
            case (dfa)
                S_IDENT: k = cut ? KIND_IDENT : ident_kind();
                S_NUM:   k = KIND_NUMBER;
                S_EQ1:   k = KIND_ASSIGN;
                S_EQ2:   k = KIND_EQ;
                default: k = KIND_PUNCT_BASE + 5'(symbol_slot(lex_text[0]));
            endcase
            for (int i = 0; i < lex_len; i++) begin
                due(k, lex_text[i], i == lex_len - 1, cut);
            end
            n_tokens++;
            if (k >= KIND_KW_BASE && k < KIND_PUNCT_BASE) n_keywords++;
            if (cut) n_cut++;
        endfunction

        function void note_byte_word(logic cmd, logic [7:0] c);
            t_cls cls;
            n_in++;
            if (cmd == CMD_END) begin
                if (!halted) emit_pending();
                clear_token();
                halted = 1'b0;
                return;
            end
            if (halted) return;
            cls = char_class(c);
            if (cls == CL_OTHER) begin
                clear_token();
                halted = 1'b1;
                due(KIND_ERROR, 8'h00, 1'b1, 1'b0);
                n_errors++;
                return;
            end
            if (grows(cls)) begin
                if (dfa == S_START) dfa = open_state(cls);
                else if (dfa == S_EQ1) dfa = S_EQ2;
            end else begin
                emit_pending();
                clear_token();
                dfa = open_state(cls);
            end
            if (cls != CL_SPACE) begin
                if (lex_len < MAX_LEN) begin
                    lex_text[lex_len] = c;
                    lex_len++;
                end else begin
                    cut = 1'b1;
                end
            end
        endfunction

        function void check_char_word(logic [4:0] kind, logic [7:0] ch, logic last,
                                      logic trunc);
            t_char_word w;
            n_out++;
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected char word kind %0d char %h last %b trunc %b",
                         $time, kind, ch, last, trunc);
                n_fail++;
                return;
            end
            w = chars_due.pop_front();
            if (kind !== w.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, w.kind, kind);
                n_fail++;
            end
            if (ch !== w.ch) begin
                $display("%0t: lexeme_char expected %h actual %h", $time, w.ch, ch);
                n_fail++;
            end
            if (last !== w.last) begin
                $display("%0t: last expected %b actual %b", $time, w.last, last);
                n_fail++;
            end
            if (trunc !== w.trunc) begin
                $display("%0t: truncated expected %b actual %b", $time, w.trunc, trunc);
                n_fail++;
            end
        endfunction
    endclass

    // every input known from time zero
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       i_command = CMD_BYTE;
    logic [7:0] i_byte_in = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [4:0] o_token_kind;
    logic [7:0] o_lexeme_char;
    logic       o_last;
    logic       o_truncated;

    lexer_scoreboard sb;
    t_src_word       src_words[$];
    int              gen_count = 0;      // words the lexer acts on, ignored ones left out
    bit              gen_halted = 1'b0;  // generator's view of the halted-on-error state
    int              full_stalls = 0;
    bit              hold_done = 1'b0;

    token_lexer_dfa dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_byte_in     (i_byte_in),
        .empty         (empty),
        .pop           (pop),
        .o_token_kind  (o_token_kind),
        .o_lexeme_char (o_lexeme_char),
        .o_last        (o_last),
        .o_truncated   (o_truncated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // stimulus building, all done before reset is released
    // ---------------------------------------------------------------

    function void add_word(logic cmd, logic [7:0] c);
        t_src_word w;
        w.cmd = cmd;
        w.ch = c;
        src_words.insert(src_words.size(), w);
        // bytes after an error byte are dropped by the lexer, so they do not count
        if (cmd == CMD_END) begin
            gen_count++;
            gen_halted = 1'b0;
        end else if (!gen_halted) begin
            gen_count++;
            gen_halted = (lexer_scoreboard::char_class(c) == CL_OTHER);
        end
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_word(CMD_BYTE, s[i]);
    endfunction

    function logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function logic [7:0] rand_alnum();
        if ($urandom_range(0, 2) == 0) return 8'("0" + $urandom_range(0, 9));
        return rand_letter();
    endfunction

    function logic [7:0] rand_sep();
        case ($urandom_range(0, 2))
            0:       return " ";
            1:       return 8'h09;
            default: return 8'h0a;
        endcase
    endfunction

    // bytes that raise an error: carriage return, high half, control codes, odd printables
    function logic [7:0] rand_bad();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = 8'h0d;
            1:       c = 8'($urandom_range(128, 255));
            2:       c = 8'($urandom_range(0, 8));
            default: begin
                do c = 8'($urandom_range(33, 126));
                while (lexer_scoreboard::char_class(c) != CL_OTHER);
            end
        endcase
        return c;
    endfunction

    function void add_ident(int n);
        add_word(CMD_BYTE, rand_letter());
        for (int i = 1; i < n; i++) add_word(CMD_BYTE, rand_alnum());
    endfunction

    function void add_digits(int n);
        for (int i = 0; i < n; i++) add_word(CMD_BYTE, 8'("0" + $urandom_range(0, 9)));
    endfunction

    function void build_directed();
        // separators in the start state, keyword, assign, eq, number cut by a letter,
        // punctuation and a newline that closes it
        add_text(" \tif=x==7z;\n");
        // error on carriage return, a letter ignored while halted, then end
        add_word(CMD_BYTE, 8'h0d);
        add_word(CMD_BYTE, "a");
        add_word(CMD_END, 8'hff);
        // both byte extremes raise an error
        add_word(CMD_BYTE, 8'hff);
        add_word(CMD_END, 8'h00);
        add_word(CMD_BYTE, 8'h00);
        add_word(CMD_END, 8'h00);
        // end item flushes a pending keyword
        add_text("else");
        add_word(CMD_END, 8'h5a);
    endfunction

    function void build_random();
        string kws[KW_NUM];
        string marks;
        int    stop_at;
        int    sel;
        int    n;
        kws = '{"if", "else", "while", "break", "continue", "return"};
        marks = ";(){}+*/<>";
        stop_at = gen_count + RANDOM_WORDS;
        while (gen_count < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 28) begin
                add_ident($urandom_range(1, 8));
            end else if (sel < 40) begin
                // exact keywords mostly, near misses now and then
                n = $urandom_range(0, KW_NUM - 1);
                case ($urandom_range(0, 5))
                    0: add_text(kws[n].substr(0, kws[n].len() - 2));
                    1: begin
                        add_text(kws[n]);
                        add_word(CMD_BYTE, rand_alnum());
                    end
                    default: add_text(kws[n]);
                endcase
            end else if (sel < 52) begin
                add_digits($urandom_range(1, 6));
                if ($urandom_range(0, 3) == 0) add_ident($urandom_range(1, 3));
            end else if (sel < 64) begin
                add_word(CMD_BYTE, marks[$urandom_range(0, 9)]);
            end else if (sel < 72) begin
                repeat ($urandom_range(1, 3)) add_word(CMD_BYTE, "=");
            end else if (sel < 76) begin
                // long lexemes around the cut point
                if ($urandom_range(0, 2) == 0) add_digits($urandom_range(31, 40));
                else add_ident($urandom_range(31, 40));
            end else if (sel < 83) begin
                add_word(CMD_END, 8'($urandom_range(0, 255)));
            end else if (sel < 90) begin
                add_word(CMD_BYTE, 8'($urandom_range(0, 255)));
            end else if (sel < 94) begin
                add_word(CMD_BYTE, rand_bad());
                repeat ($urandom_range(0, 4)) add_word(CMD_BYTE, 8'($urandom_range(0, 255)));
                add_word(CMD_END, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) add_word(CMD_BYTE, rand_sep());
            end
            if ($urandom_range(0, 1) == 0) add_word(CMD_BYTE, rand_sep());
            // a stray error byte usually gets its end item soon, so few tokens go to waste
            if (gen_halted && $urandom_range(0, 3) != 0) begin
                add_word(CMD_END, 8'($urandom_range(0, 255)));
            end
        end
        add_word(CMD_END, 8'($urandom_range(0, 255)));
    endfunction

    // ---------------------------------------------------------------
    // sender: bursts of random length, random gaps in between
    // ---------------------------------------------------------------

    task automatic send_all();
        int burst;
        int gap;
        while (src_words.size() > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            while (burst > 0 && src_words.size() > 0) begin
                push <= 1'b1;
                i_command <= src_words[0].cmd;
                i_byte_in <= src_words[0].ch;
                @(posedge i_clk);
                // full as seen just before this edge decides acceptance
                while (full !== 1'b0) begin
                    full_stalls++;
                    @(posedge i_clk);
                end
                sb.note_byte_word(src_words[0].cmd, src_words[0].ch);
                src_words.delete(0);
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver: stall pattern switches between random phases, plus one
    // long hold that backs the lexer up until it drops full on the sender
    // ---------------------------------------------------------------

    initial begin : receiver
        t_rx_mode mode;
        int       phase_left;
        int       tick;
        int       hold_left;
        mode = RX_STREAM;
        phase_left = 0;
        tick = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && empty === 1'b0) begin
                sb.check_char_word(o_token_kind, o_lexeme_char, o_last, o_truncated);
            end
            if (!hold_done && sb.n_in >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                phase_left = $urandom_range(24, 96);
            end
            phase_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    RX_STREAM:      pop <= 1'b1;
                    RX_COIN:        pop <= 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: pop <= (tick % 3 != 0);
                    default:        pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // main flow: reset, send, drain, report
    // ---------------------------------------------------------------

    initial begin : main
        int waited;
        sb = new();
        build_directed();
        build_random();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_all();
        waited = 0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() > 0) begin
            $display("%0t: %0d char words never arrived", $time, sb.pending());
            $display("FAIL token_lexer_dfa");
        end else begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("run covered %0d input words (%0d cycles held off by full), %0d char words",
                     sb.n_in, full_stalls, sb.n_out);
            $display("tokens %0d, keywords %0d, truncated %0d, error words %0d",
                     sb.n_tokens, sb.n_keywords, sb.n_cut, sb.n_errors);
            if (sb.n_fail == 0) begin
                $display("PASS token_lexer_dfa");
            end else begin
                $display("FAIL token_lexer_dfa");
            end
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_TIME);
        $display("FAIL token_lexer_dfa");
        $finish;
    end

endmodule
